@@ sv/c_aware_brace_matcher_macros.svh @@
// Assertion macros used by the brace matcher RTL.
`ifndef C_AWARE_BRACE_MATCHER_MACROS_SVH
`define C_AWARE_BRACE_MATCHER_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define CABM_ASSERT(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Antecedent seen at one edge implies the consequent at the next edge.
`define CABM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/cabm_pkg.sv @@
package cabm_pkg;

   localparam int POSITION_BITS = 16;
   localparam int TEXT_W        = 8;
   localparam int POS_W         = 16;
   localparam int DEPTH_W       = 16;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_ADDR_W    = 3;

   // register index within the csr space (byte address / 4)
   localparam logic CSR_IDX_START_POSITION = 1'b0;

   localparam logic [TEXT_W-1:0] CH_LBRACE    = 8'h7B;
   localparam logic [TEXT_W-1:0] CH_RBRACE    = 8'h7D;
   localparam logic [TEXT_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [TEXT_W-1:0] CH_STAR      = 8'h2A;
   localparam logic [TEXT_W-1:0] CH_SLASH     = 8'h2F;
   localparam logic [TEXT_W-1:0] CH_BACKSLASH = 8'h5C;
   localparam logic [TEXT_W-1:0] CH_DQUOTE    = 8'h22;
   localparam logic [TEXT_W-1:0] CH_SQUOTE    = 8'h27;

   typedef struct packed {
      logic [TEXT_W-1:0] text_byte;
      logic              first_byte;
      logic              last_byte;
   } req_item_type;

   typedef struct packed {
      logic             valid;
      logic             found;
      logic [POS_W-1:0] match_position;
   } scan_result_type;

endpackage

@@ sv/cabm_csr.sv @@
module cabm_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [cabm_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [cabm_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [cabm_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready,
   output logic [cabm_pkg::POS_W-1:0]         start_position
);
   import cabm_pkg::*;

   logic [POS_W-1:0] start_pos_ff;
   logic [POS_W-1:0] start_pos_in;
   logic             sel_start;
   logic             wr_en;

   assign csr_pready = 1'b1;
   assign sel_start  = (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_START_POSITION);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      start_pos_in = start_pos_ff;
      if (wr_en && sel_start) begin
         start_pos_in = csr_pwdata[POS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_pos_ff <= '0;
      end else begin
         start_pos_ff <= start_pos_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (sel_start) begin
         csr_prdata = CSR_DATA_W'(start_pos_ff);
      end
   end

   assign start_position = start_pos_ff;

endmodule

@@ sv/cabm_scan.sv @@
module cabm_scan (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step_en,
   input  cabm_pkg::req_item_type         item,
   input  logic [cabm_pkg::POS_W-1:0]     start_position,
   output cabm_pkg::scan_result_type      res
);
   import cabm_pkg::*;
   `include "c_aware_brace_matcher_macros.svh"

   typedef enum logic [8:0] {
      MODE_CODE       = 9'b000000001,
      MODE_SLASH      = 9'b000000010,
      MODE_LINE       = 9'b000000100,
      MODE_BLOCK      = 9'b000001000,
      MODE_BLOCK_STAR = 9'b000010000,
      MODE_STR        = 9'b000100000,
      MODE_STR_ESC    = 9'b001000000,
      MODE_CHR        = 9'b010000000,
      MODE_CHR_ESC    = 9'b100000000
   } lex_mode_type;

   lex_mode_type             mode_ff, mode_in, mode_cur;
   logic [DEPTH_W-1:0]       depth_ff, depth_in, depth_cur;
   logic [POSITION_BITS-1:0] count_ff, count_in, count_cur;
   logic                     done_ff, done_in;
   logic                     active;
   logic                     code_ctx;
   logic                     hit;
   logic [POSITION_BITS-1:0] pos_sum;
   logic [TEXT_W-1:0]        c;

   assign c = item.text_byte;

   always_comb begin
      mode_cur  = item.first_byte ? MODE_CODE : mode_ff;
      depth_cur = item.first_byte ? '0 : depth_ff;
      count_cur = item.first_byte ? '0 : count_ff;
      active    = item.first_byte || !done_ff;

      mode_in  = mode_cur;
      depth_in = depth_cur;
      code_ctx = 1'b0;
      hit      = 1'b0;

      case (mode_cur)
         MODE_SLASH: begin
            if (c == CH_SLASH) begin
               mode_in = MODE_LINE;
            end else if (c == CH_STAR) begin
               mode_in = MODE_BLOCK;
            end else begin
               // lone slash: this byte is plain code
               mode_in  = MODE_CODE;
               code_ctx = 1'b1;
            end
         end
         MODE_LINE: begin
            if (c == CH_NEWLINE) mode_in = MODE_CODE;
         end
         MODE_BLOCK: begin
            if (c == CH_STAR) mode_in = MODE_BLOCK_STAR;
         end
         MODE_BLOCK_STAR: begin
            if (c == CH_SLASH) begin
               mode_in = MODE_CODE;
            end else if (c != CH_STAR) begin
               mode_in = MODE_BLOCK;
            end
         end
         MODE_STR: begin
            if (c == CH_BACKSLASH) begin
               mode_in = MODE_STR_ESC;
            end else if (c == CH_DQUOTE) begin
               mode_in = MODE_CODE;
            end
         end
         MODE_STR_ESC: begin
            mode_in = MODE_STR;
         end
         MODE_CHR: begin
            if (c == CH_BACKSLASH) begin
               mode_in = MODE_CHR_ESC;
            end else if (c == CH_SQUOTE) begin
               mode_in = MODE_CODE;
            end
         end
         MODE_CHR_ESC: begin
            mode_in = MODE_CHR;
         end
         default: begin
            mode_in  = MODE_CODE;
            code_ctx = 1'b1;
         end
      endcase

      if (code_ctx) begin
         case (c)
            CH_DQUOTE: mode_in = MODE_STR;
            CH_SQUOTE: mode_in = MODE_CHR;
            CH_SLASH:  mode_in = MODE_SLASH;
            CH_LBRACE: depth_in = depth_cur + 1'b1;
            CH_RBRACE: begin
               depth_in = depth_cur - 1'b1;
               hit      = (depth_in == '0);
            end
            default: ;
         endcase
      end
   end

   assign pos_sum = POSITION_BITS'(start_position) + count_cur;

   always_comb begin
      res      = '0;
      count_in = count_cur;
      done_in  = done_ff;
      if (active) begin
         if (hit) begin
            res.valid          = 1'b1;
            res.found          = 1'b1;
            res.match_position = POS_W'(pos_sum);
            done_in            = 1'b1;
         end else begin
            count_in = count_cur + 1'b1;
            done_in  = 1'b0;
            if (item.last_byte) begin
               res.valid = 1'b1;
               done_in   = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_CODE;
         depth_ff <= '0;
         count_ff <= '0;
         done_ff  <= 1'b1;
      end else if (step_en && active) begin
         mode_ff  <= mode_in;
         depth_ff <= depth_in;
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   `CABM_ASSERT_NEXT(a_done_after_result, step_en && res.valid, done_ff,
      "search not closed after its result")
   `CABM_ASSERT(a_notfound_pos_zero, !(res.valid && !res.found) || (res.match_position == '0),
      "not-found result carries a nonzero position")
   `CABM_ASSERT(a_idle_silent, !(done_ff && !item.first_byte) || !res.valid,
      "result produced while idle")

endmodule

@@ sv/c_aware_brace_matcher.sv @@
// Matching-brace scanner for C/C++ text.
// Input channel req_*: one source byte per word in req_tdata, req_tuser marks
// the first byte of a search (the opening brace, at start_position), req_tlast
// marks the final byte of the text. Bytes of an idle block without the first
// flag are dropped. Braces in comments, strings and char literals are ignored.
// Result channel rsp_*: at most one word per search. rsp_tuser is 1 with the
// absolute position of the closing brace in rsp_tdata, or 0 with position 0
// when the text ended first.
// csr_* writes start_position at byte address 0; write it only while idle.
// Throughput: one byte per cycle while the receiver does not stall. Bytes pass
// through the input register, then the lexer into the result register.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more byte; the lexer stops when both are full, and
// req_tready falls only then.
// Reset: lexer in code mode, depth and byte count zero, block idle awaiting a
// first byte, start_position zero, both registers empty.
module c_aware_brace_matcher (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,   // text_byte
   input  logic [0:0]                         req_tuser,   // first_byte
   input  logic                               req_tlast,   // last_byte
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [15:0]                        rsp_tdata,   // match_position
   output logic [0:0]                         rsp_tuser,   // found
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [cabm_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [cabm_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [cabm_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import cabm_pkg::*;

   logic             in_valid_ff, in_valid_in;
   req_item_type     in_item_ff, in_item_in;
   logic             out_valid_ff, out_valid_in;
   logic             out_found_ff, out_found_in;
   logic [POS_W-1:0] out_pos_ff, out_pos_in;
   logic             step_en;
   logic             req_take;
   logic [POS_W-1:0] start_position;
   scan_result_type  res;

   cabm_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .start_position (start_position)
   );

   cabm_scan u_scan (
      .clock          (clock),
      .reset          (reset),
      .step_en        (step_en),
      .item           (in_item_ff),
      .start_position (start_position),
      .res            (res)
   );

   // the held word moves on when the result register is free or draining
   assign step_en    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step_en;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_take) begin
         in_valid_in          = 1'b1;
         in_item_in.text_byte = req_tdata;
         in_item_in.first_byte = req_tuser[0];
         in_item_in.last_byte = req_tlast;
      end else if (step_en) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_found_in = out_found_ff;
      out_pos_in   = out_pos_ff;
      if (step_en && res.valid) begin
         out_valid_in = 1'b1;
         out_found_in = res.found;
         out_pos_in   = res.match_position;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff   <= in_item_in;
      out_found_ff <= out_found_in;
      out_pos_ff   <= out_pos_in;
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_pos_ff;
   assign rsp_tuser[0] = out_found_ff;

endmodule
